// File: hdl/haversine_distance_range_check_top_assert.svh
// assertion macros shared by the block's modules
// each macro expects clk_i and rst_ni in scope
`ifndef HAVERSINE_DISTANCE_RANGE_CHECK_TOP_ASSERT_SVH
`define HAVERSINE_DISTANCE_RANGE_CHECK_TOP_ASSERT_SVH

// same-cycle implication
`define HDRC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HDRC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/hdrc_pkg.sv
package hdrc_pkg;

  localparam int STEP_W = 5;
  typedef logic [STEP_W-1:0] step_t;

  // angle selects for the four sine/cosine passes
  localparam logic [1:0] ANG_HLAT = 2'd0;
  localparam logic [1:0] ANG_HLON = 2'd1;
  localparam logic [1:0] ANG_LAT1 = 2'd2;
  localparam logic [1:0] ANG_LAT2 = 2'd3;

  localparam step_t RED_LAST = step_t'(9);
  localparam step_t SQ_LAST  = step_t'(31);

  localparam logic signed [33:0] CORDIC_INV_GAIN = 34'sd652032874;
  localparam logic signed [33:0] DEG2RAD_Q32     = 34'sd74961321;
  localparam logic [60:0]        Q60_ONE         = 61'h1000_0000_0000_0000;
  localparam logic [24:0]        DIST_MAX        = 25'h1FF_FFFF;
  localparam logic [22:0]        RADIUS_RESET    = 23'd6371000;

  typedef enum logic [4:0] {
    OP_NONE, OP_ACCEPT, OP_ANG_LOAD, OP_ANG_RED, OP_ANG_FOLD, OP_RAD_MUL, OP_RAD_SET,
    OP_ROT, OP_ROT_SAVE, OP_V1_MUL, OP_V1_SET, OP_V2_MUL, OP_V2_SET, OP_VV_MUL,
    OP_SS_MUL, OP_A_SET, OP_SQ_INIT, OP_SQ_STEP, OP_SQ_SAVE, OP_VEC_STEP, OP_D_MUL,
    OP_D_SET, OP_LOAD_OUT
  } op_e;

  typedef enum logic [4:0] {
    S_IDLE, S_ANG_LOAD, S_ANG_RED, S_ANG_FOLD, S_RAD_MUL, S_RAD_SET, S_ROT, S_ROT_SAVE,
    S_V1_MUL, S_V1_SET, S_V2_MUL, S_V2_SET, S_VV_MUL, S_SS_MUL, S_A_SET, S_SQ_INIT,
    S_SQ_STEP, S_SQ_SAVE, S_VEC_STEP, S_D_MUL, S_D_SET, S_OUT
  } state_e;

  typedef struct packed {
    op_e        op;
    logic [1:0] ang_sel;
    logic       sq_sel;
    step_t      step;
  } dp_cmd_t;

  typedef struct packed {
    logic have_fix;
  } dp_stat_t;

  // atan(2^-i) in Q30
  function automatic logic signed [33:0] atan_q30(input logic [4:0] i);
    logic signed [33:0] v;
    unique case (i)
      5'd0:    v = 34'sd843314857;
      5'd1:    v = 34'sd497837830;
      5'd2:    v = 34'sd263043837;
      5'd3:    v = 34'sd133525159;
      5'd4:    v = 34'sd67021687;
      5'd5:    v = 34'sd33543516;
      5'd6:    v = 34'sd16775851;
      5'd7:    v = 34'sd8388437;
      5'd8:    v = 34'sd4194283;
      5'd9:    v = 34'sd2097149;
      5'd10:   v = 34'sd1048576;
      default: v = signed'(34'd1073741824 >> i);
    endcase
    return v;
  endfunction

endpackage

// File: hdl/haversine_distance_range_check_top.sv
// channel   direction  handshake                     payload
// s_axis    in         s_axis_tvalid/s_axis_tready   tuser command, tdata lat/lon/range
// m_axis    out        m_axis_tvalid/m_axis_tready   tdata distance, flags, stored fix
// cfg       in         cfg_valid_i/cfg_ready_o       earth radius in meters
//
// an update request, or a query before any fix, goes from accept straight to the output state
// a query with a fix first runs four serial cordic rotations, two 32-step square roots
// and one cordic vectoring pass before it reaches the output state
// one request in flight; a new request is taken once the result sits in the output register
// a stalled output holds the finished result; reset clears the fix and loads the default radius
module haversine_distance_range_check_top #(
  parameter int COORD_FRAC_BITS   = 23,
  parameter int CORDIC_ITERATIONS = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [87:0] s_axis_tdata,  // point_lat[30:0], point_lon[62:31], range_m[87:63]
  input  logic [0:0]  s_axis_tuser,  // command[0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [95:0] m_axis_tdata,  // distance_m[24:0], in_range[25], fix_valid[26],
                                     // fix_lat[57:27], fix_lon[89:58], zero[95:90]
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [22:0] cfg_data_i
);
  import hdrc_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready_o = 1'b1;

  // sequencer
  hdrc_ctrl #(
    .CORDIC_ITERATIONS(CORDIC_ITERATIONS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_query_i  (s_axis_tuser[0]),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // arithmetic and fix storage
  hdrc_datapath #(
    .COORD_FRAC_BITS(COORD_FRAC_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (s_axis_tdata),
    .in_query_i  (s_axis_tuser[0]),
    .out_data_o  (m_axis_tdata)
  );

endmodule

// File: hdl/hdrc_ctrl.sv
module hdrc_ctrl #(
  parameter int CORDIC_ITERATIONS = 24
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_query_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  hdrc_pkg::dp_stat_t stat_i,
  output hdrc_pkg::dp_cmd_t  cmd_o
);
  import hdrc_pkg::*;

  localparam step_t ITER_LAST = step_t'(CORDIC_ITERATIONS - 1);

  state_e     state_q, state_d;
  step_t      step_q, step_d;
  logic [1:0] sel_q, sel_d;
  logic       sq_sel_q, sq_sel_d;
  logic       out_valid_q, out_valid_d;
  logic       load_out;

  assign load_out = (state_q == S_OUT) && (!out_valid_q || out_ready_i);

  // next state and sequencing counters
  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    sel_d       = sel_q;
    sq_sel_d    = sq_sel_q;
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          sel_d   = ANG_HLAT;
          state_d = (in_query_i && stat_i.have_fix) ? S_ANG_LOAD : S_OUT;
        end
      end
      S_ANG_LOAD: begin
        step_d  = RED_LAST;
        state_d = S_ANG_RED;
      end
      S_ANG_RED: begin
        if (step_q == '0) begin
          state_d = S_ANG_FOLD;
        end else begin
          step_d = step_q - step_t'(1);
        end
      end
      S_ANG_FOLD: state_d = S_RAD_MUL;
      S_RAD_MUL:  state_d = S_RAD_SET;
      S_RAD_SET: begin
        step_d  = '0;
        state_d = S_ROT;
      end
      S_ROT: begin
        if (step_q == ITER_LAST) begin
          state_d = S_ROT_SAVE;
        end else begin
          step_d = step_q + step_t'(1);
        end
      end
      S_ROT_SAVE: begin
        if (sel_q == ANG_LAT2) begin
          state_d = S_V1_MUL;
        end else begin
          sel_d   = sel_q + 2'd1;
          state_d = S_ANG_LOAD;
        end
      end
      S_V1_MUL: state_d = S_V1_SET;
      S_V1_SET: state_d = S_V2_MUL;
      S_V2_MUL: state_d = S_V2_SET;
      S_V2_SET: state_d = S_VV_MUL;
      S_VV_MUL: state_d = S_SS_MUL;
      S_SS_MUL: state_d = S_A_SET;
      S_A_SET: begin
        sq_sel_d = 1'b0;
        state_d  = S_SQ_INIT;
      end
      S_SQ_INIT: begin
        step_d  = '0;
        state_d = S_SQ_STEP;
      end
      S_SQ_STEP: begin
        if (step_q == SQ_LAST) begin
          state_d = S_SQ_SAVE;
        end else begin
          step_d = step_q + step_t'(1);
        end
      end
      S_SQ_SAVE: begin
        if (!sq_sel_q) begin
          sq_sel_d = 1'b1;
          state_d  = S_SQ_INIT;
        end else begin
          step_d  = '0;
          state_d = S_VEC_STEP;
        end
      end
      S_VEC_STEP: begin
        if (step_q == ITER_LAST) begin
          state_d = S_D_MUL;
        end else begin
          step_d = step_q + step_t'(1);
        end
      end
      S_D_MUL: state_d = S_D_SET;
      S_D_SET: state_d = S_OUT;
      S_OUT: begin
        if (load_out) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd_o.ang_sel = sel_q;
    cmd_o.sq_sel  = sq_sel_q;
    cmd_o.step    = step_q;
    unique case (state_q)
      S_IDLE:     cmd_o.op = in_valid_i ? OP_ACCEPT : OP_NONE;
      S_ANG_LOAD: cmd_o.op = OP_ANG_LOAD;
      S_ANG_RED:  cmd_o.op = OP_ANG_RED;
      S_ANG_FOLD: cmd_o.op = OP_ANG_FOLD;
      S_RAD_MUL:  cmd_o.op = OP_RAD_MUL;
      S_RAD_SET:  cmd_o.op = OP_RAD_SET;
      S_ROT:      cmd_o.op = OP_ROT;
      S_ROT_SAVE: cmd_o.op = OP_ROT_SAVE;
      S_V1_MUL:   cmd_o.op = OP_V1_MUL;
      S_V1_SET:   cmd_o.op = OP_V1_SET;
      S_V2_MUL:   cmd_o.op = OP_V2_MUL;
      S_V2_SET:   cmd_o.op = OP_V2_SET;
      S_VV_MUL:   cmd_o.op = OP_VV_MUL;
      S_SS_MUL:   cmd_o.op = OP_SS_MUL;
      S_A_SET:    cmd_o.op = OP_A_SET;
      S_SQ_INIT:  cmd_o.op = OP_SQ_INIT;
      S_SQ_STEP:  cmd_o.op = OP_SQ_STEP;
      S_SQ_SAVE:  cmd_o.op = OP_SQ_SAVE;
      S_VEC_STEP: cmd_o.op = OP_VEC_STEP;
      S_D_MUL:    cmd_o.op = OP_D_MUL;
      S_D_SET:    cmd_o.op = OP_D_SET;
      S_OUT:      cmd_o.op = load_out ? OP_LOAD_OUT : OP_NONE;
      default:    cmd_o.op = OP_NONE;
    endcase
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      sel_q       <= ANG_HLAT;
      sq_sel_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      sel_q       <= sel_d;
      sq_sel_q    <= sq_sel_d;
      out_valid_q <= out_valid_d;
    end
  end

`include "haversine_distance_range_check_top_assert.svh"

  `HDRC_ASSERT_NEXT(a_query_starts, (state_q == S_IDLE) && in_valid_i && in_query_i && stat_i.have_fix, (state_q == S_ANG_LOAD) && (sel_q == ANG_HLAT), "query with fix did not start")
  `HDRC_ASSERT_NOW(a_iter_bound, (state_q == S_ROT) || (state_q == S_VEC_STEP), step_q <= ITER_LAST, "cordic step out of range")
  `HDRC_ASSERT_NEXT(a_load_sets_valid, load_out, out_valid_q, "result load lost")

endmodule

// File: hdl/hdrc_datapath.sv
module hdrc_datapath #(
  parameter int COORD_FRAC_BITS = 23
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  hdrc_pkg::dp_cmd_t  cmd_i,
  output hdrc_pkg::dp_stat_t stat_o,
  input  logic               cfg_valid_i,
  input  logic [22:0]        cfg_data_i,
  input  logic [87:0]        in_data_i,
  input  logic               in_query_i,
  output logic [95:0]        out_data_o
);
  import hdrc_pkg::*;

  localparam int CF = COORD_FRAC_BITS;
  localparam logic [43:0] FULL_F = 44'd360 << CF;
  localparam logic [43:0] FULL_H = 44'd360 << (CF + 1);
  localparam logic [43:0] H180_F = 44'd180 << CF;
  localparam logic [43:0] H180_H = 44'd180 << (CF + 1);
  localparam logic [43:0] H90_F  = 44'd90 << CF;
  localparam logic [43:0] H90_H  = 44'd90 << (CF + 1);

  // item and stored fix
  logic signed [30:0] lat_q, fix_lat_q;
  logic signed [31:0] lon_q, fix_lon_q;
  logic [24:0]        range_q;
  logic               have_fix_q;
  logic [22:0]        radius_q;

  // working registers
  logic [43:0]        r_q;
  logic               sneg_q, cneg_q, half_q;
  logic signed [67:0] product_q, acc_q;
  logic signed [33:0] cx_q, cy_q, cz_q;
  logic signed [33:0] s_hl_q, s_hn_q, c1_q, c2_q, v1_q, v2_q;
  logic [60:0]        a_q;
  logic [63:0]        sq_v_q, sq_res_q;
  logic [24:0]        dist_q;
  logic               inr_q;
  logic [95:0]        out_q;

  // combinational helpers
  logic [43:0]        full_sel, h180_sel, h90_sel, red_sub, m1, r_load;
  logic signed [32:0] ang;
  logic signed [33:0] mul_a, mul_b, dx, dy, atan_i, cos_v, sin_v;
  logic signed [67:0] z_rad;
  logic signed [68:0] a_sum;
  logic [63:0]        sq_bit, sq_trial;
  logic signed [67:0] d_q30;
  logic [24:0]        d_sat;
  logic signed [33:0] z_pos;

  assign full_sel = half_q ? FULL_H : FULL_F;
  assign h180_sel = half_q ? H180_H : H180_F;
  assign h90_sel  = half_q ? H90_H : H90_F;
  assign red_sub  = full_sel << cmd_i.step;
  assign m1       = (r_q >= h180_sel) ? (full_sel - r_q) : r_q;

  // angle source for the sine/cosine pass
  always_comb begin
    unique case (cmd_i.ang_sel)
      ANG_HLAT: ang = 33'(lat_q) - 33'(fix_lat_q);
      ANG_HLON: ang = 33'(lon_q) - 33'(fix_lon_q);
      ANG_LAT1: ang = 33'(fix_lat_q);
      default:  ang = 33'(lat_q);
    endcase
  end
  // bias keeps the value positive before the modulo reduction
  assign r_load = 44'(ang) + (((cmd_i.ang_sel == ANG_HLAT) || (cmd_i.ang_sel == ANG_HLON)) ?
                              (FULL_H << 9) : (FULL_F << 9));

  // shared multiplier operands
  always_comb begin
    unique case (cmd_i.op)
      OP_RAD_MUL: begin
        mul_a = signed'({3'b000, r_q[30:0]});
        mul_b = DEG2RAD_Q32;
      end
      OP_V1_MUL: begin
        mul_a = s_hn_q;
        mul_b = c1_q;
      end
      OP_V2_MUL: begin
        mul_a = s_hn_q;
        mul_b = c2_q;
      end
      OP_VV_MUL: begin
        mul_a = v1_q;
        mul_b = v2_q;
      end
      OP_SS_MUL: begin
        mul_a = s_hl_q;
        mul_b = s_hl_q;
      end
      default: begin
        mul_a = z_pos;
        mul_b = signed'({10'b0, radius_q, 1'b0});
      end
    endcase
  end

  assign z_pos = cz_q[33] ? 34'sd0 : cz_q;
  assign z_rad = half_q ? ((product_q + (68'sd1 <<< (CF + 2))) >>> (CF + 3))
                        : ((product_q + (68'sd1 <<< (CF + 1))) >>> (CF + 2));

  // cordic step terms
  assign dx     = cy_q >>> cmd_i.step;
  assign dy     = cx_q >>> cmd_i.step;
  assign atan_i = atan_q30(5'(cmd_i.step));
  assign cos_v  = cneg_q ? -cx_q : cx_q;
  assign sin_v  = sneg_q ? -cy_q : cy_q;

  assign a_sum    = 69'(acc_q) + 69'(product_q);
  assign sq_bit   = 64'd1 << (6'd62 - {cmd_i.step, 1'b0});
  assign sq_trial = sq_res_q + sq_bit;
  assign d_q30    = (product_q + 68'sd536870912) >>> 30;
  assign d_sat    = (d_q30 > 68'(DIST_MAX)) ? DIST_MAX : d_q30[24:0];

  // control-side registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_fix_q <= 1'b0;
      fix_lat_q  <= '0;
      fix_lon_q  <= '0;
      radius_q   <= RADIUS_RESET;
    end else begin
      if (cfg_valid_i) begin
        radius_q <= cfg_data_i;
      end
      if ((cmd_i.op == OP_ACCEPT) && !in_query_i) begin
        have_fix_q <= 1'b1;
        fix_lat_q  <= signed'(in_data_i[30:0]);
        fix_lon_q  <= signed'(in_data_i[62:31]);
      end
    end
  end

  // working datapath
  always_ff @(posedge clk_i) begin
    product_q <= 68'(mul_a) * 68'(mul_b);
    case (cmd_i.op)
      OP_ACCEPT: begin
        lat_q   <= signed'(in_data_i[30:0]);
        lon_q   <= signed'(in_data_i[62:31]);
        range_q <= in_data_i[87:63];
        dist_q  <= '0;
        inr_q   <= 1'b0;
      end
      OP_ANG_LOAD: begin
        r_q    <= r_load;
        half_q <= (cmd_i.ang_sel == ANG_HLAT) || (cmd_i.ang_sel == ANG_HLON);
      end
      OP_ANG_RED: begin
        if (r_q >= red_sub) begin
          r_q <= r_q - red_sub;
        end
      end
      OP_ANG_FOLD: begin
        sneg_q <= (r_q >= h180_sel);
        cneg_q <= (m1 > h90_sel);
        r_q    <= (m1 > h90_sel) ? (h180_sel - m1) : m1;
      end
      OP_RAD_SET: begin
        cz_q <= 34'(z_rad);
        cx_q <= CORDIC_INV_GAIN;
        cy_q <= '0;
      end
      OP_ROT: begin
        if (!cz_q[33]) begin
          cx_q <= cx_q - dx;
          cy_q <= cy_q + dy;
          cz_q <= cz_q - atan_i;
        end else begin
          cx_q <= cx_q + dx;
          cy_q <= cy_q - dy;
          cz_q <= cz_q + atan_i;
        end
      end
      OP_ROT_SAVE: begin
        unique case (cmd_i.ang_sel)
          ANG_HLAT: s_hl_q <= sin_v;
          ANG_HLON: s_hn_q <= sin_v;
          ANG_LAT1: c1_q   <= cos_v;
          default:  c2_q   <= cos_v;
        endcase
      end
      OP_V1_SET: v1_q <= 34'((product_q + 68'sd536870912) >>> 30);
      OP_V2_SET: v2_q <= 34'((product_q + 68'sd536870912) >>> 30);
      OP_SS_MUL: acc_q <= product_q;
      OP_A_SET: begin
        if (a_sum < 0) begin
          a_q <= '0;
        end else if (a_sum > 69'(Q60_ONE)) begin
          a_q <= Q60_ONE;
        end else begin
          a_q <= a_sum[60:0];
        end
      end
      OP_SQ_INIT: begin
        sq_v_q   <= cmd_i.sq_sel ? 64'(Q60_ONE - a_q) : 64'(a_q);
        sq_res_q <= '0;
      end
      OP_SQ_STEP: begin
        if (sq_v_q >= sq_trial) begin
          sq_v_q   <= sq_v_q - sq_trial;
          sq_res_q <= (sq_res_q >> 1) + sq_bit;
        end else begin
          sq_res_q <= sq_res_q >> 1;
        end
      end
      OP_SQ_SAVE: begin
        if (!cmd_i.sq_sel) begin
          cy_q <= signed'({3'b000, sq_res_q[30:0]});
        end else begin
          cx_q <= signed'({3'b000, sq_res_q[30:0]});
          cz_q <= '0;
        end
      end
      OP_VEC_STEP: begin
        if (!cy_q[33]) begin
          cx_q <= cx_q + dx;
          cy_q <= cy_q - dy;
          cz_q <= cz_q + atan_i;
        end else begin
          cx_q <= cx_q - dx;
          cy_q <= cy_q + dy;
          cz_q <= cz_q - atan_i;
        end
      end
      OP_D_SET: begin
        dist_q <= d_sat;
        inr_q  <= (d_sat < range_q);
      end
      OP_LOAD_OUT: out_q <= {6'b0, fix_lon_q, fix_lat_q, have_fix_q, inr_q, dist_q};
      default: ;
    endcase
  end

  assign stat_o.have_fix = have_fix_q;
  assign out_data_o      = out_q;

`include "haversine_distance_range_check_top_assert.svh"

  `HDRC_ASSERT_NOW(a_a_clamped, cmd_i.op == OP_SQ_INIT, a_q <= Q60_ONE, "haversine term out of range")
  `HDRC_ASSERT_NOW(a_inr_consistent, cmd_i.op == OP_LOAD_OUT, !inr_q || (dist_q < range_q), "in-range flag disagrees with distance")
  `HDRC_ASSERT_NEXT(a_fix_sticky, have_fix_q, have_fix_q, "position fix flag cleared")

endmodule

// File: dv/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC_BITS = 23;
  localparam int ITERS = 24;
  localparam longint CYCLE_LIMIT = 3000000;
  localparam longint INV_GAIN = 652032874;
  localparam longint DEG_RAD_Q32 = 74961321;
  localparam longint Q60 = longint'(1) << 60;
  localparam longint LAT_MAX = 754974720;
  localparam longint LON_MAX = 1509949440;
  localparam longint DIST_SAT = 33554431;

  typedef enum bit {CMD_UPDATE = 1'b0, CMD_QUERY = 1'b1} cmd_e;

  typedef struct {
    cmd_e               cmd;
    logic signed [30:0] lat;
    logic signed [31:0] lon;
    logic [24:0]        rng;
  } fix_req_t;

  typedef struct {
    logic [24:0]        dist_m;
    logic               inr;
    logic               fv;
    logic signed [30:0] lat;
    logic signed [31:0] lon;
  } fix_rsp_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        s_valid = 1'b0;
  logic [87:0] s_data = '0;
  logic [0:0]  s_user = '0;
  logic        m_ready = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [22:0] cfg_data = '0;
  logic        s_ready, m_valid, cfg_ready;
  logic [95:0] m_data;

  haversine_distance_range_check_top dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .s_axis_tuser  (s_user),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_data_i    (cfg_data)
  );

  // predictor state
  longint   fix_lat_q, fix_lon_q;
  bit       fix_held;
  longint   radius_q;
  fix_req_t pending_reqs[$];
  fix_rsp_t expected_rsps[$];
  fix_req_t cur_req;
  int       send_idle = 0, recv_idle = 0;
  bit       pressure_go = 0;
  int       errors = 0;
  int       n_update = 0, n_query = 0, n_near = 0, n_rsp = 0;
  longint   cycles = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic longint atan_tab(input int i);
    longint head[11] = '{843314857, 497837830, 263043837, 133525159, 67021687, 33543516,
                         16775851, 8388437, 4194283, 2097149, 1048576};
    if (i < 11) return head[i];
    if (i > 30) return 0;
    return (longint'(1) << 30) >>> i;
  endfunction

  // cordic rotation, angle in degrees scaled by 2^f, outputs q30
  task automatic sin_cos_q30(input longint ang, input int f, output longint c, output longint s);
    longint full, r, x, y, z, dx, dy;
    bit sneg, cneg;
    full = longint'(360) << f;
    r = ang % full;
    if (r < 0) r += full;
    if (r >= (longint'(180) << f)) r -= full;
    sneg = r < 0;
    if (sneg) r = -r;
    cneg = 0;
    if (r > (longint'(90) << f)) begin
      r = (longint'(180) << f) - r;
      cneg = 1;
    end
    z = (r * DEG_RAD_Q32 + (longint'(1) << (f + 1))) >>> (f + 2);
    x = INV_GAIN;
    y = 0;
    for (int i = 0; i < ITERS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_tab(i);
      end else begin
        x += dx; y -= dy; z += atan_tab(i);
      end
    end
    c = cneg ? -x : x;
    s = sneg ? -y : y;
  endtask

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = longint'(1) << 62;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // haversine distance from the held fix, meters, saturated
  task automatic great_circle_m(input longint lat, input longint lon, output longint d);
    longint c_hl, s_hl, c_hn, s_hn, c1, s1, c2, s2, v1, v2, a, x, y, z, dx, dy;
    sin_cos_q30(lat - fix_lat_q, FRAC_BITS + 1, c_hl, s_hl);
    sin_cos_q30(lon - fix_lon_q, FRAC_BITS + 1, c_hn, s_hn);
    sin_cos_q30(fix_lat_q, FRAC_BITS, c1, s1);
    sin_cos_q30(lat, FRAC_BITS, c2, s2);
    v1 = (s_hn * c1 + (longint'(1) << 29)) >>> 30;
    v2 = (s_hn * c2 + (longint'(1) << 29)) >>> 30;
    a = s_hl * s_hl + v1 * v2;
    if (a < 0) a = 0;
    if (a > Q60) a = Q60;
    y = int_sqrt(a);
    x = int_sqrt(Q60 - a);
    z = 0;
    for (int i = 0; i < ITERS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += atan_tab(i);
      end else begin
        x -= dx; y += dy; z -= atan_tab(i);
      end
    end
    if (z < 0) z = 0;
    d = (z * radius_q * 2 + (longint'(1) << 29)) >>> 30;
    if (d > DIST_SAT) d = DIST_SAT;
  endtask

  // expected response of one accepted request, updates the held fix
  task automatic predict_fix_rsp(input fix_req_t rq);
    fix_rsp_t rs;
    longint d;
    rs.dist_m = '0;
    rs.inr = 1'b0;
    if (rq.cmd == CMD_UPDATE) begin
      fix_lat_q = rq.lat;
      fix_lon_q = rq.lon;
      fix_held = 1;
      n_update++;
    end else begin
      n_query++;
      if (fix_held) begin
        great_circle_m(rq.lat, rq.lon, d);
        rs.dist_m = d[24:0];
        rs.inr = d < rq.rng;
        if (rs.inr) n_near++;
      end
    end
    rs.fv = fix_held;
    rs.lat = fix_lat_q[30:0];
    rs.lon = fix_lon_q[31:0];
    expected_rsps.push_back(rs);
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (s_valid && s_ready) predict_fix_rsp(cur_req);
      if (!s_valid || s_ready) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle) begin
          cur_req = pending_reqs.pop_front();
          s_valid <= 1'b1;
          s_user <= cur_req.cmd;
          s_data <= {cur_req.rng, cur_req.lon, cur_req.lat};
        end else begin
          s_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold once pressure starts
  int  hold_cnt = 0;
  bit  hold_done = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (pressure_go && !hold_done) begin
        hold_done <= 1'b1;
        hold_cnt <= 1500;
      end else if (hold_cnt > 0) begin
        hold_cnt <= hold_cnt - 1;
      end
    end
  end

  // response monitor with receiver stalls
  always @(posedge clk) begin
    fix_rsp_t ex;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
    if (rst_n) begin
      if (m_valid && m_ready) begin
        n_rsp++;
        if (expected_rsps.size() == 0) begin
          $error("response with no request pending: %h", m_data);
          errors++;
        end else begin
          ex = expected_rsps.pop_front();
          if (m_data[24:0] !== ex.dist_m) begin
            $error("distance_m exp %0d got %0d", ex.dist_m, m_data[24:0]); errors++;
          end
          if (m_data[25] !== ex.inr) begin
            $error("in_range exp %0d got %0d", ex.inr, m_data[25]); errors++;
          end
          if (m_data[26] !== ex.fv) begin
            $error("fix_valid exp %0d got %0d", ex.fv, m_data[26]); errors++;
          end
          if (m_data[57:27] !== ex.lat) begin
            $error("fix_lat exp %h got %h", ex.lat, m_data[57:27]); errors++;
          end
          if (m_data[89:58] !== ex.lon) begin
            $error("fix_lon exp %h got %h", ex.lon, m_data[89:58]); errors++;
          end
        end
      end
      if (hold_cnt > 0) begin
        m_ready <= 1'b0;
      end else begin
        m_ready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  task automatic push_req(input cmd_e c, input longint lat, input longint lon,
                          input longint rng);
    fix_req_t rq;
    rq.cmd = c;
    rq.lat = lat[30:0];
    rq.lon = lon[31:0];
    rq.rng = rng[24:0];
    pending_reqs.push_back(rq);
  endtask

  function automatic longint rand_lat();
    return longint'($urandom_range(0, 1509949440)) - LAT_MAX;
  endfunction

  function automatic longint rand_lon();
    return longint'($urandom_range(0, 32'd3019898880)) - LON_MAX;
  endfunction

  // one fix followed by a few queries, near and far
  task automatic push_track();
    longint flat, flon;
    int nq;
    if ($urandom_range(9) == 0) begin
      flat = $urandom; flon = $urandom;
    end else begin
      flat = rand_lat(); flon = rand_lon();
    end
    push_req(CMD_UPDATE, flat, flon, $urandom);
    nq = $urandom_range(1, 4);
    repeat (nq) begin
      case ($urandom_range(3))
        0, 1: push_req(CMD_QUERY, flat + $signed($urandom_range(0, 262144)) - 131072,
                       flon + $signed($urandom_range(0, 262144)) - 131072,
                       $urandom_range(0, 4000));
        2: push_req(CMD_QUERY, rand_lat(), rand_lon(), $urandom_range(0, 30000000));
        default: push_req(CMD_QUERY, $urandom, $urandom, $urandom);
      endcase
    end
  endtask

  task automatic write_radius(input logic [22:0] r);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= r;
    do @(posedge clk); while (!cfg_ready);
    radius_q = r;
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_reqs.size() != 0 || s_valid || expected_rsps.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  initial begin
    logic [22:0] radii[4] = '{23'd6400000, 23'd6300000, 23'h7FFFFF, 23'd0};
    int sends[4] = '{19, 73, 0, 0};
    int recvs[4] = '{73, 19, 0, 0};
    int counts[4] = '{180, 180, 180, 50};
    fix_lat_q = 0;
    fix_lon_q = 0;
    fix_held = 0;
    radius_q = 6371000;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    for (int ph = 0; ph < 4; ph++) begin
      write_radius(radii[ph]);
      send_idle = sends[ph];
      recv_idle = recvs[ph];
      if (ph == 0) begin
        // query before any fix, then extremes, antipode and wrapped coordinates
        push_req(CMD_QUERY, LAT_MAX, LON_MAX, DIST_SAT);
        push_req(CMD_UPDATE, 0, 0, 0);
        push_req(CMD_QUERY, 0, 0, 0);
        push_req(CMD_QUERY, 0, 0, 1);
        push_req(CMD_QUERY, 0, LON_MAX, DIST_SAT);
        push_req(CMD_QUERY, 0, -LON_MAX, DIST_SAT);
        push_req(CMD_QUERY, LAT_MAX, 0, DIST_SAT);
        push_req(CMD_QUERY, -LAT_MAX, 0, 20000000);
        push_req(CMD_UPDATE, LAT_MAX, LON_MAX, DIST_SAT);
        push_req(CMD_QUERY, -LAT_MAX, -LON_MAX, DIST_SAT);
        push_req(CMD_QUERY, LAT_MAX, LON_MAX, 0);
        push_req(CMD_UPDATE, -LAT_MAX, -LON_MAX, 0);
        push_req(CMD_QUERY, 32'h3FFF_FFFF, 32'h7FFF_FFFF, DIST_SAT);
        push_req(CMD_QUERY, 32'h4000_0000, 32'h8000_0000, 0);
        push_req(CMD_UPDATE, 32'h3FFF_FFFF, 32'h7FFF_FFFF, DIST_SAT);
        push_req(CMD_QUERY, 32'h4000_0000, 32'h8000_0000, DIST_SAT);
        push_req(CMD_QUERY, 32'h3FFF_FFFF, 32'h7FFF_FFFF, 1);
        push_req(CMD_UPDATE, 32'h4000_0000, 32'h8000_0000, 0);
        push_req(CMD_QUERY, 0, 0, DIST_SAT);
      end
      if (ph == 2) pressure_go = 1;
      for (int k = 0; k < counts[ph]; k += 3) push_track();
      drain();
    end
    repeat (300) @(posedge clk);
    if (expected_rsps.size() != 0) begin
      $error("%0d responses never arrived", expected_rsps.size());
      errors++;
    end
    $display("covered %0d fix updates and %0d distance queries (%0d within range), %0d responses",
             n_update, n_query, n_near, n_rsp);
    $display("four earth radius settings including 0 and all ones, with and without stalls");
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
